/* rtl/core/hotp_pkg.sv */
// hotp_pkg: shared types and constants for the one-time code generator
// no dependencies
package hotp_pkg;

  localparam int KeyBytesDefault = 40;
  localparam int KeyRegs         = 5;
  localparam int KeyIdxW         = 3;
  localparam int CfgDataW        = 64;
  localparam int FactorW         = 64;
  localparam int DigitsW         = 4;
  localparam int CodeW           = 27;

  localparam logic [DigitsW-1:0] DigitsSix   = 4'd6;
  localparam logic [DigitsW-1:0] DigitsEight = 4'd8;
  localparam logic [31:0] ModSix   = 32'd1000000;
  localparam logic [31:0] ModEight = 32'd100000000;

  // reciprocals: ceil(2^51 / 10^6) and ceil(2^58 / 10^8), exact for 31-bit values
  localparam logic [31:0] MagicSix   = 32'd2251799814;
  localparam logic [31:0] MagicEight = 32'd2882303762;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  localparam logic [159:0] ShaInit =
    160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

  typedef struct packed {
    logic [FactorW-1:0] moving_factor;
    logic [DigitsW-1:0] digit_count;
  } hotp_req_t;

  typedef struct packed {
    logic [CodeW-1:0] otp_code;
    logic             code_ok;
  } hotp_rsp_t;

  // handshake between sequencer and compression engine
  typedef struct packed {
    logic start;
    logic chain;
  } sha_ctl_t;

  function automatic logic [31:0] sha_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5a827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ed9eba1;
    end else if (rnd < 7'd60) begin
      k = 32'h8f1bbcdc;
    end else begin
      k = 32'hca62c1d6;
    end
    return k;
  endfunction

  function automatic logic [31:0] sha_f(input logic [6:0] rnd, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40 || rnd >= 7'd60) begin
      f = b ^ c ^ d;
    end else begin
      f = (b & c) | (b & d) | (c & d);
    end
    return f;
  endfunction

endpackage

/* rtl/core/hotp_if.sv */
// hotp_if: valid/ready channel carrying one payload beat
// no dependencies; the payload type is set by the payload_t parameter
interface hotp_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/hotp_code_generator_unit.sv */
// hotp_code_generator_unit: hmac-sha1 one-time code generator, top level
// depends on hotp_pkg, hotp_if, hotp_sha1_core, hotp_mod_unit
//
// One request beat yields one result beat. The request is handled alone: four sha-1
// compressions through a single round engine at one round per clock, then a
// reciprocal-multiply remainder unit; an invalid digit count skips the remainder and
// returns code_ok low. A new request is taken only once the result beat has been
// taken. Key registers are written through the write port and must not change while
// a request is in flight.
module hotp_code_generator_unit #(
  parameter int KEY_BYTES = hotp_pkg::KeyBytesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hotp_pkg::KeyIdxW-1:0]  cfg_index,
  input  logic [hotp_pkg::CfgDataW-1:0] cfg_data,
  hotp_if.sink                          req,
  hotp_if.source                        rsp
);
  import hotp_pkg::*;

  localparam int KeyLen = (KEY_BYTES < 1) ? 1 : ((KEY_BYTES > 40) ? 40 : KEY_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_IN1   = 7'b0000010,
    S_IN2   = 7'b0000100,
    S_OUT1  = 7'b0001000,
    S_OUT2  = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  logic [CfgDataW-1:0] key [KeyRegs];
  logic [FactorW-1:0]  factor;
  logic [DigitsW-1:0]  digits;
  logic [159:0]        inner;
  logic                started;
  hotp_rsp_t           result;

  logic [511:0] kblk, sblk;
  logic [159:0] h_out;
  logic         sha_done;
  sha_ctl_t     ctl;
  logic         mod_start, mod_done;
  logic [26:0]  rem;
  logic [30:0]  bin;
  logic [3:0]   off;
  logic         dig_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyRegs; i++) key[i] <= '0;
    end else if (cfg_we && cfg_index < KeyIdxW'(KeyRegs)) begin
      key[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    kblk = '0;
    for (int i = 0; i < KeyLen; i++) begin
      kblk[511 - 8*i -: 8] = key[i/8][63 - 8*(i%8) -: 8];
    end
  end

  always_comb begin
    sblk = '0;
    case (state)
      S_IN1:   sblk = kblk ^ {64{IpadByte}};
      S_IN2:   sblk = {factor, 8'h80, 376'h0, 64'd576};
      S_OUT1:  sblk = kblk ^ {64{OpadByte}};
      S_OUT2:  sblk = {inner, 8'h80, 280'h0, 64'd672};
      default: sblk = '0;
    endcase
  end

  assign ctl.start = (state == S_IN1 || state == S_IN2 || state == S_OUT1 ||
                      state == S_OUT2) && !started;
  assign ctl.chain = (state == S_IN2 || state == S_OUT2);

  hotp_sha1_core u_sha (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .blk  (sblk),
    .h_in (ShaInit),
    .done (sha_done),
    .h_out(h_out)
  );

  assign off = h_out[3:0];
  always_comb begin
    bin = '0;
    for (int j = 0; j < 16; j++) begin
      if (off == 4'(j)) bin = h_out[159 - 8*j - 1 -: 31];
    end
  end

  assign dig_valid = (digits == DigitsSix) || (digits == DigitsEight);
  assign mod_start = (state == S_MOD) && !started;

  hotp_mod_unit u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (bin),
    .eight (digits == DigitsEight),
    .done  (mod_done),
    .rem   (rem)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          started <= 1'b0;
          if (req.valid) begin
            factor <= req.data.moving_factor;
            digits <= req.data.digit_count;
            state  <= S_IN1;
          end
        end
        S_IN1, S_IN2, S_OUT1, S_OUT2: begin
          started <= 1'b1;
          if (sha_done) begin
            started <= 1'b0;
            case (state)
              S_IN1:   state <= S_IN2;
              S_IN2:   state <= S_OUT1;
              S_OUT1:  state <= S_OUT2;
              default: state <= S_MOD;
            endcase
          end
        end
        S_MOD: begin
          started <= 1'b1;
          if (!dig_valid) begin
            result <= '{otp_code: '0, code_ok: 1'b0};
            state  <= S_DONE;
          end else if (mod_done) begin
            result <= '{otp_code: rem, code_ok: 1'b1};
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // inner digest is on h_out during the first outer-pass cycle
  always_ff @(posedge clk) begin
    if (state == S_OUT1 && !started) inner <= h_out;
  end
endmodule

/* rtl/core/hotp_sha1_core.sv */
// hotp_sha1_core: one sha-1 compression, one round per clock, 16-word schedule window
// depends on hotp_pkg
module hotp_sha1_core (
  input  logic                 clk,
  input  logic                 rst,
  input  hotp_pkg::sha_ctl_t   ctl,
  input  logic [511:0]         blk,
  input  logic [159:0]         h_in,
  output logic                 done,
  output logic [159:0]         h_out
);
  import hotp_pkg::*;

  logic [31:0]  a, b, c, d, e;
  logic [511:0] win;
  logic [6:0]   rnd;
  logic         busy;
  logic [159:0] hbase;
  logic [31:0]  w_cur, w_new, t;

  assign w_cur = win[511:480];
  assign w_new = win[447:416] ^ win[255:224] ^ win[95:64] ^ win[511:480];
  assign t = {a[26:0], a[31:27]} + sha_f(rnd, b, c, d) + e + sha_k(rnd) + w_cur;

  logic [31:0] w_rot;
  assign w_rot = {w_new[30:0], w_new[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        rnd   <= '0;
        win   <= blk;
        hbase <= ctl.chain ? h_out : h_in;
        {a, b, c, d, e} <= ctl.chain ? h_out : h_in;
      end else if (busy) begin
        e   <= d;
        d   <= c;
        c   <= {b[1:0], b[31:2]};
        b   <= a;
        a   <= t;
        win <= {win[479:0], w_rot};
        if (rnd == 7'd79) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        rnd <= rnd + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      h_out <= {hbase[159:128] + a, hbase[127:96] + b, hbase[95:64] + c,
                hbase[63:32] + d, hbase[31:0] + e};
    end
  end
endmodule

/* rtl/core/hotp_mod_unit.sv */
// hotp_mod_unit: remainder of a 31-bit value by 10^6 or 10^8 by reciprocal multiply
// depends on hotp_pkg
module hotp_mod_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] value,
  input  logic        eight,
  output logic        done,
  output logic [26:0] rem
);
  import hotp_pkg::*;

  logic [30:0] x;
  logic        eight_r;
  logic [62:0] prod;
  logic [11:0] q;
  logic [30:0] qm;
  logic [30:0] r;
  logic        s1, s2;
  logic [31:0] magic;
  logic [30:0] modulus;

  assign magic   = eight ? MagicEight : MagicSix;
  assign modulus = eight_r ? ModEight[30:0] : ModSix[30:0];
  assign qm      = {19'd0, q} * modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= start;
      s2   <= s1;
      done <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x       <= value;
      eight_r <= eight;
      prod    <= {32'd0, value} * {31'd0, magic};
    end
    if (s1) begin
      q <= eight_r ? {7'd0, prod[62:58]} : prod[62:51];
    end
    if (s2) begin
      r <= x - qm;
    end
  end

  assign rem = r[26:0];
endmodule
